### rtl/core/adm3a_pkg.sv
// Shared types and codes for the ADM-3A host stream command decoder.
`default_nettype none

package adm3a_pkg;

    // Field widths
    localparam int ByteW   = 8;
    localparam int ActionW = 4;
    localparam int PosW    = 9;
    localparam int OutW    = 32;
    localparam int CfgIdxW = 2;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgCharMask   = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgSuppress   = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgTransPrint = 2'd2;

    // Character codes used by the decoder
    localparam logic [ByteW-1:0] ChEsc   = 8'h1B;
    localparam logic [ByteW-1:0] ChDel   = 8'h7F;
    localparam logic [ByteW-1:0] ChEq    = 8'h3D;
    localparam logic [ByteW-1:0] ChT     = 8'h54;
    localparam logic [ByteW-1:0] ChY     = 8'h59;
    localparam logic [ByteW-1:0] ChEnq   = 8'h05;
    localparam logic [ByteW-1:0] ChBel   = 8'h07;
    localparam logic [ByteW-1:0] ChBs    = 8'h08;
    localparam logic [ByteW-1:0] ChLf    = 8'h0A;
    localparam logic [ByteW-1:0] ChVt    = 8'h0B;
    localparam logic [ByteW-1:0] ChFf    = 8'h0C;
    localparam logic [ByteW-1:0] ChCr    = 8'h0D;
    localparam logic [ByteW-1:0] ChSo    = 8'h0E;
    localparam logic [ByteW-1:0] ChSi    = 8'h0F;
    localparam logic [ByteW-1:0] ChSub   = 8'h1A;
    localparam logic [ByteW-1:0] ChRs    = 8'h1E;
    localparam logic [ByteW-1:0] PosBias = 8'd31;

    // Display action codes
    typedef enum logic [ActionW-1:0] {
        ACT_NONE       = 4'd0,
        ACT_PRINT      = 4'd1,
        ACT_ANSWERBACK = 4'd2,
        ACT_BELL       = 4'd3,
        ACT_LEFT       = 4'd4,
        ACT_LF         = 4'd5,
        ACT_UP         = 4'd6,
        ACT_RIGHT      = 4'd7,
        ACT_CR         = 4'd8,
        ACT_LOCK       = 4'd9,
        ACT_UNLOCK     = 4'd10,
        ACT_CLEAR      = 4'd11,
        ACT_HOME       = 4'd12,
        ACT_GOTO       = 4'd13,
        ACT_CLR_EOL    = 4'd14,
        ACT_CLR_EOS    = 4'd15
    } t_action;

    // Escape sequence phase, one-hot
    typedef enum logic [3:0] {
        PH_NORMAL = 4'b0001,
        PH_ESC    = 4'b0010,
        PH_LINE   = 4'b0100,
        PH_COL    = 4'b1000
    } t_phase;

    // Configuration registers
    typedef struct packed {
        logic [ByteW-1:0] char_mask;
        logic             suppress_display;
        logic             transparent_print;
    } t_cfg;

    // One decoded result word
    typedef struct packed {
        logic signed [PosW-1:0] target_row;
        logic signed [PosW-1:0] target_column;
        logic [ByteW-1:0]       glyph;
        t_action                action;
    } t_result;

endpackage

`default_nettype wire

### rtl/core/adm3a_decode.sv
// Escape sequence state and single-byte decode into one display action.
`default_nettype none

module adm3a_decode (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_advance,
    input  wire logic [adm3a_pkg::ByteW-1:0] i_byte,
    input  wire adm3a_pkg::t_cfg           i_cfg,
    output adm3a_pkg::t_result             o_result
);

    adm3a_pkg::t_phase            r_phase, n_phase;
    logic [adm3a_pkg::ByteW-1:0]  r_held, n_held;
    logic [adm3a_pkg::ByteW-1:0]  c;
    adm3a_pkg::t_action           ctl_act;
    logic                         quiet;

    assign c     = i_byte & i_cfg.char_mask;
    assign quiet = i_cfg.suppress_display;

    // Control code table
    always_comb begin
        case (c)
            adm3a_pkg::ChEnq: ctl_act = adm3a_pkg::ACT_ANSWERBACK;
            adm3a_pkg::ChBel: ctl_act = adm3a_pkg::ACT_BELL;
            adm3a_pkg::ChBs:  ctl_act = adm3a_pkg::ACT_LEFT;
            adm3a_pkg::ChLf:  ctl_act = adm3a_pkg::ACT_LF;
            adm3a_pkg::ChVt:  ctl_act = adm3a_pkg::ACT_UP;
            adm3a_pkg::ChFf:  ctl_act = adm3a_pkg::ACT_RIGHT;
            adm3a_pkg::ChCr:  ctl_act = adm3a_pkg::ACT_CR;
            adm3a_pkg::ChSo:  ctl_act = adm3a_pkg::ACT_LOCK;
            adm3a_pkg::ChSi:  ctl_act = adm3a_pkg::ACT_UNLOCK;
            adm3a_pkg::ChSub: ctl_act = adm3a_pkg::ACT_CLEAR;
            adm3a_pkg::ChRs:  ctl_act = adm3a_pkg::ACT_HOME;
            default:          ctl_act = adm3a_pkg::ACT_NONE;
        endcase
    end

    // Decode by phase
    always_comb begin
        n_phase  = r_phase;
        n_held   = r_held;
        o_result = '0;
        case (r_phase)
            adm3a_pkg::PH_ESC: begin
                n_phase = adm3a_pkg::PH_NORMAL;
                if (c == adm3a_pkg::ChEq) begin
                    n_phase = adm3a_pkg::PH_LINE;
                end else if (c == adm3a_pkg::ChT && !quiet) begin
                    o_result.action = adm3a_pkg::ACT_CLR_EOL;
                end else if (c == adm3a_pkg::ChY && !quiet) begin
                    o_result.action = adm3a_pkg::ACT_CLR_EOS;
                end
            end
            adm3a_pkg::PH_LINE: begin
                n_held  = c;
                n_phase = adm3a_pkg::PH_COL;
            end
            adm3a_pkg::PH_COL: begin
                n_phase = adm3a_pkg::PH_NORMAL;
                if (!quiet) begin
                    o_result.action        = adm3a_pkg::ACT_GOTO;
                    o_result.target_column = {1'b0, c} - {1'b0, adm3a_pkg::PosBias};
                    o_result.target_row    = {1'b0, r_held} - {1'b0, adm3a_pkg::PosBias};
                end
            end
            default: begin
                if (c inside {[8'h00:8'h1F]}) begin
                    // control codes, silenced by transparent print or suppress display
                    if (!i_cfg.transparent_print && !quiet) begin
                        if (c == adm3a_pkg::ChEsc) begin
                            n_phase = adm3a_pkg::PH_ESC;
                        end else begin
                            o_result.action = ctl_act;
                        end
                    end
                end else if (!quiet && c != adm3a_pkg::ChDel) begin
                    o_result.action = adm3a_pkg::ACT_PRINT;
                    o_result.glyph  = c;
                end
            end
        endcase
    end

    // State update when the word moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= adm3a_pkg::PH_NORMAL;
            r_held  <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

`default_nettype wire

### rtl/core/adm3a_command_decoder_unit.sv
// Top level of the ADM-3A command decoder: input register, decode, result register.
//
//  channel   | dir | handshake                      | payload
//  s_axis    | in  | i_s_axis_tvalid/o_s_axis_tready | tdata[7:0] rx_byte
//  m_axis    | out | o_m_axis_tvalid/i_m_axis_tready | tdata[31:0] action, glyph, col, row
//  cfg write | in  | i_cfg_valid/o_cfg_ready         | i_cfg_index, i_cfg_data
//
// One word per cycle sustained while the output side is not stalled.
// The input register feeds one decode pass into the result register.
// Reset (synchronous, active low) empties both registers, returns the escape
// phase to normal and loads the register reset values.
// A stalled result register holds its word; the input register keeps taking a
// word while the result register is full only if the input register is empty.
`default_nettype none

module adm3a_command_decoder_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // rx_byte[7:0]
    input  wire logic [7:0]  i_s_axis_tdata,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // action[3:0], glyph[11:4], target_column[20:12], target_row[29:21], zero[31:30]
    output logic [31:0]      o_m_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    adm3a_pkg::t_cfg               r_cfg;
    logic                          r_in_valid;
    logic [adm3a_pkg::ByteW-1:0]   r_in_byte;
    logic                          r_out_valid;
    adm3a_pkg::t_result            r_out;
    adm3a_pkg::t_result            dec_result;
    logic                          out_free;
    logic                          advance;
    logic                          s_accept;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign advance         = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.char_mask         <= 8'hFF;
            r_cfg.suppress_display  <= 1'b0;
            r_cfg.transparent_print <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                adm3a_pkg::CfgCharMask:   r_cfg.char_mask         <= i_cfg_data;
                adm3a_pkg::CfgSuppress:   r_cfg.suppress_display  <= i_cfg_data[0];
                adm3a_pkg::CfgTransPrint: r_cfg.transparent_print <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    adm3a_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_advance(advance),
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .o_result (dec_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= dec_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out};

    // Checks
    a_ready_low_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_in_valid && r_out_valid))
        else $error("input stalled with a free stage");

    a_accept_fills_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> r_in_valid)
        else $error("accepted word lost");

    a_glyph_only_print: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.glyph != '0) |-> (r_out.action == adm3a_pkg::ACT_PRINT))
        else $error("glyph set without print");

    a_pos_only_goto: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.target_column != '0 || r_out.target_row != '0))
        |-> (r_out.action == adm3a_pkg::ACT_GOTO))
        else $error("position set without goto");

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 100ps
// Self-checking stream testbench for the ADM-3A command decoder unit.
module tb;
    import adm3a_pkg::*;

    localparam int ClkHalf   = 6;
    localparam int ResetCyc  = 11;
    localparam int MaxGap    = 6;
    localparam int DrainWait = 4;
    localparam int IdleLimit = 400;
    localparam int ReportMax = 10;
    localparam int PhaseLen  = 200;
    localparam int NumPhases = 8;

    // Register index past the end of the map, must be ignored
    localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_AFTER_ESC,
        SEQ_ROW,
        SEQ_COL
    } t_seq;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic [7:0]  i_s_axis_tdata = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;

    // Decoder model: sequence state and register copies
    t_seq       seq_state = SEQ_IDLE;
    logic [7:0] held_row = '0;
    logic [7:0] mask_reg = 8'hFF;
    logic       suppress_reg = 1'b0;
    logic       transparent_reg = 1'b0;

    t_result expected_words[$];
    logic    full_rate = 1'b0;
    int      fail_count = 0;
    int      bytes_sent = 0;
    int      words_checked = 0;
    int      gotos_checked = 0;
    int      reg_writes = 0;
    int      idle_cycles = 0;

    initial begin
        forever #ClkHalf i_clk = ~i_clk;
    end

    adm3a_command_decoder_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Single control codes outside a sequence
    function automatic t_action control_code(input logic [7:0] c);
        case (c)
            ChEnq:   return ACT_ANSWERBACK;
            ChBel:   return ACT_BELL;
            ChBs:    return ACT_LEFT;
            ChLf:    return ACT_LF;
            ChVt:    return ACT_UP;
            ChFf:    return ACT_RIGHT;
            ChCr:    return ACT_CR;
            ChSo:    return ACT_LOCK;
            ChSi:    return ACT_UNLOCK;
            ChSub:   return ACT_CLEAR;
            ChRs:    return ACT_HOME;
            default: return ACT_NONE;
        endcase
    endfunction

    // Expected result word for one received byte; advances the model state
    function automatic t_result decode_byte(input logic [7:0] raw);
        logic [7:0] c;
        t_result    r;
        c = raw & mask_reg;
        r = '0;
        case (seq_state)
            SEQ_AFTER_ESC: begin
                seq_state = SEQ_IDLE;
                if (c == ChEq) begin
                    seq_state = SEQ_ROW;
                end else if (c == ChT) begin
                    if (!suppress_reg) r.action = ACT_CLR_EOL;
                end else if (c == ChY) begin
                    if (!suppress_reg) r.action = ACT_CLR_EOS;
                end
            end
            SEQ_ROW: begin
                held_row = c;
                seq_state = SEQ_COL;
            end
            SEQ_COL: begin
                seq_state = SEQ_IDLE;
                if (!suppress_reg) begin
                    r.action = ACT_GOTO;
                    r.target_column = {1'b0, c} - {1'b0, PosBias};
                    r.target_row = {1'b0, held_row} - {1'b0, PosBias};
                end
            end
            default: begin
                if (c < 8'h20) begin
                    if (!transparent_reg && !suppress_reg) begin
                        if (c == ChEsc) seq_state = SEQ_AFTER_ESC;
                        else r.action = control_code(c);
                    end
                end else if (!suppress_reg && c != ChDel) begin
                    r.action = ACT_PRINT;
                    r.glyph = c;
                end
            end
        endcase
        return r;
    endfunction

    // Cursor operand: mostly on-screen positions, sometimes any byte
    function automatic logic [7:0] operand_byte();
        logic [31:0] v;
        if ($urandom_range(0, 3) == 0) v = $urandom;
        else v = $urandom_range(8'h20, 8'h6F);
        return v[7:0];
    endfunction

    // Send one byte on the input stream and record its expected word
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = full_rate ? 0 : $urandom_range(0, MaxGap);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tdata <= b;
        i_s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        expected_words.push_back(decode_byte(b));
        bytes_sent++;
    endtask

    // Stop sending and wait until every expected word has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
    endtask

    // One register write; only called with the pipeline empty
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CfgCharMask:   mask_reg = val;
            CfgSuppress:   suppress_reg = val[0];
            CfgTransPrint: transparent_reg = val[0];
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Byte extremes, every control code and the three escape forms
    task automatic test_directed_codes();
        send_byte(8'h00); send_byte(8'hFF); send_byte(ChDel); send_byte(8'h20);
        send_byte(ChEnq); send_byte(ChBel); send_byte(ChBs); send_byte(ChLf);
        send_byte(ChVt); send_byte(ChFf); send_byte(ChCr); send_byte(ChSo);
        send_byte(ChSi); send_byte(ChSub); send_byte(ChRs);
        send_byte(ChEsc); send_byte(ChT);
        send_byte(ChEsc); send_byte(ChY);
        send_byte(ChEsc); send_byte(8'h28);
        // goto to the far corners: row -31, column 224
        send_byte(ChEsc); send_byte(ChEq); send_byte(8'h00); send_byte(8'hFF);
        drain_results();
    endtask

    // Mode changes while a sequence is open, masked register values
    task automatic test_sequence_modes();
        // transparent print leaves a begun sequence alone
        send_byte(ChEsc);
        drain_results();
        write_reg(CfgTransPrint, 8'h01);
        send_byte(ChEq); send_byte(ChCr); send_byte(ChEsc);
        send_byte(ChEsc); send_byte(ChBel); send_byte(8'h41);
        drain_results();
        write_reg(CfgTransPrint, 8'h00);
        // suppress arriving mid-goto still consumes the column byte
        send_byte(ChEsc); send_byte(ChEq); send_byte(8'h41);
        drain_results();
        write_reg(CfgSuppress, 8'hFF);
        send_byte(8'h42); send_byte(ChEsc); send_byte(ChT);
        drain_results();
        write_reg(CfgSuppress, 8'hFE);
        write_reg(CfgUnused, 8'h00);
        // ESC and a control code as the byte after ESC both end the sequence
        send_byte(ChEsc); send_byte(ChEsc); send_byte(ChT);
        send_byte(ChEsc); send_byte(ChCr);
        drain_results();
    endtask

    // Mostly well-formed sequences with random content, plus noise
    task automatic test_random_stream();
        int          start;
        int          kind;
        logic [31:0] junk;
        logic [7:0]  m;
        for (int p = 0; p < NumPhases; p++) begin
            case (p)
                0:       m = 8'hFF;
                1:       m = 8'h00;
                2:       m = 8'h7F;
                default: m = 8'($urandom_range(0, 255));
            endcase
            junk = $urandom;
            write_reg(CfgCharMask, m);
            write_reg(CfgSuppress, {junk[7:1], p % 4 == 3});
            write_reg(CfgTransPrint, {junk[15:9], p % 3 == 2});
            if (p == 5) write_reg(CfgUnused, junk[23:16]);
            full_rate = (p % 3 == 1);
            start = bytes_sent;
            while (bytes_sent - start < PhaseLen) begin
                if ($urandom_range(0, 63) == 0) full_rate = ~full_rate;
                kind = $urandom_range(0, 9);
                junk = $urandom;
                case (kind)
                    0, 1, 2: send_byte(8'($urandom_range(8'h20, 8'hFF)));
                    3:       send_byte(8'($urandom_range(0, 8'h1F)));
                    4, 5, 6: begin
                        send_byte(ChEsc); send_byte(ChEq);
                        send_byte(operand_byte()); send_byte(operand_byte());
                    end
                    7: begin
                        send_byte(ChEsc);
                        send_byte(junk[0] ? ChT : ChY);
                    end
                    8: begin
                        send_byte(ChEsc);
                        send_byte(junk[15:8]);
                    end
                    default: send_byte(junk[7:0]);
                endcase
            end
            drain_results();
        end
        full_rate = 1'b0;
    endtask

    // Output side: random stall before each word, with full-rate stretches
    initial begin : result_sink
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = full_rate ? 0 : $urandom_range(0, MaxGap);
            @(negedge i_clk);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
        end
    end

    // Compare every accepted word against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_result'(o_m_axis_tdata[29:0]);
            if (expected_words.size() == 0) begin
                fail_count++;
                if (fail_count <= ReportMax)
                    $display("unexpected word %h at %0t", o_m_axis_tdata, $realtime);
            end else begin
                want = expected_words.pop_front();
                words_checked++;
                if (want.action == ACT_GOTO) gotos_checked++;
                if (got.action !== want.action || got.glyph !== want.glyph ||
                    got.target_column !== want.target_column ||
                    got.target_row !== want.target_row || o_m_axis_tdata[31:30] !== 2'b00) begin
                    fail_count++;
                    if (fail_count <= ReportMax) begin
                        $display("mismatch word %0d: exp act=%0d gl=%h col=%0d row=%0d pad=0",
                                 words_checked, want.action, want.glyph, want.target_column,
                                 want.target_row);
                        $display("    got act=%0d gl=%h col=%0d row=%0d pad=%b",
                                 got.action, got.glyph, got.target_column,
                                 got.target_row, o_m_axis_tdata[31:30]);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run if no word moves on any channel for too long
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("watchdog: no word moved for %0d cycles", IdleLimit);
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Test sequence
    initial begin
        repeat (ResetCyc) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_codes();
        test_sequence_modes();
        test_random_stream();
        drain_results();
        if (expected_words.size() != 0) begin
            $display("%0d expected words never arrived", expected_words.size());
            fail_count += expected_words.size();
        end
        $display("covered: %0d bytes in, %0d words checked (%0d cursor moves), %0d reg writes",
                 bytes_sent, words_checked, gotos_checked, reg_writes);
        $display("masks 00/7F/FF and random, suppress and transparent modes, %0d faults",
                 fail_count);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/adm3a_pkg.sv
rtl/core/adm3a_decode.sv
rtl/core/adm3a_command_decoder_unit.sv
bench/tb.sv
